// ===== hw/rtl/qpe_pkg.sv =====
`timescale 1ns / 1ps

package qpe_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int KLEN_W     = 4;
    localparam int KPOS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_TEXT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        PH_KEY   = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_SKIP  = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ESC_IDLE   = 3'b001,
        ESC_FIRST  = 3'b010,
        ESC_SECOND = 3'b100
    } esc_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       value_end;
        logic       found;
        logic       malformed;
    } out_item_t;

    typedef struct packed {
        logic     fire;
        in_item_t item;
    } step_t;

    typedef struct packed {
        logic      have;
        out_item_t item;
    } res_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // bit 4 set when c is a hex digit, low nibble holds its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/qpe_stream_if.sv =====
`timescale 1ns / 1ps

interface qpe_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/query_param_extract_url_decode.sv =====
`timescale 1ns / 1ps

// channel   dir   payload                                        transaction
// query     in    in_byte, in_last                               one raw character
// value     out   out_byte, byte_valid, value_end, found, malf.  one decoded byte or end mark
// cfg       in    cfg_write, cfg_index, cfg_data                 one register write
//
// one character per cycle unless value stalls, passing input then result register to value
// the parser state loop (input register to result register) is the single step
// reset clears parser state, both pipeline valids and the key registers
// a stalled value output holds the result; the input register still takes one more
// character, after which query.ready follows value.ready

module query_param_extract_url_decode #(
    parameter int KEY_CHARS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    qpe_stream_if.sink                        query,
    qpe_stream_if.source                      value,
    input  logic                              cfg_write,
    input  logic [qpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import qpe_pkg::*;

    logic [KEY_CHARS*8-1:0] key_text_reg;
    logic [KLEN_W-1:0]      key_length_reg;

    logic                   in_valid_reg, in_valid_next;
    in_item_t               in_item_reg;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg;

    logic                   out_free;
    logic                   advance;
    step_t                  step;
    res_t                   res;

    assign out_free    = !out_valid_reg || value.ready;
    assign advance     = in_valid_reg && out_free;
    assign query.ready = !in_valid_reg || advance;

    assign step.fire = advance;
    assign step.item = in_item_reg;

    qpe_parser #(
        .KEY_CHARS (KEY_CHARS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_text   (key_text_reg),
        .key_length (key_length_reg),
        .step       (step),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_TEXT:   key_text_reg   <= cfg_data[KEY_CHARS*8-1:0];
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = (query.valid && query.ready) || (in_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = res.have;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query.valid && query.ready)
        begin
            in_item_reg <= query.payload;
        end
        if (advance && res.have)
        begin
            out_item_reg <= res.item;
        end
    end

    assign value.valid   = out_valid_reg;
    assign value.payload = out_item_reg;

    // flags only ride on the end mark
    a_flags_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        value.valid && !value.payload.value_end
            |-> !value.payload.found && !value.payload.malformed)
        else $error("found or malformed set on a non-final result");

    // every result carries a byte or the end mark
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        value.valid |-> value.payload.byte_valid || value.payload.value_end)
        else $error("empty result emitted");

    // byte is zero when not valid, and never zero when valid
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        value.valid |-> (value.payload.byte_valid == (value.payload.out_byte != 8'd0)))
        else $error("out_byte inconsistent with byte_valid");

    // a held character stays in the input register while the output stalls
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_item_reg))
        else $error("input register lost a pending character");

endmodule

// ===== hw/rtl/qpe_parser.sv =====
`timescale 1ns / 1ps

module qpe_parser #(
    parameter int KEY_CHARS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [KEY_CHARS*8-1:0]       key_text,
    input  logic [qpe_pkg::KLEN_W-1:0]   key_length,
    input  qpe_pkg::step_t               step,
    output qpe_pkg::res_t                res
);
    import qpe_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [KPOS_W-1:0]   pos_reg, pos_next;
    logic                mis_reg, mis_next;
    logic                seen_reg, seen_next;
    logic [3:0]          esc_val_reg, esc_val_next;
    esc_t                esc_reg, esc_next;
    logic                cut_reg, cut_next;
    logic                bad_reg, bad_next;

    logic [7:0]          want;
    logic                key_in_range;
    logic                key_fit;

    function automatic logic key_match(input logic [KPOS_W-1:0] pos, input logic mis,
                                       input logic fit, input logic [KLEN_W-1:0] klen);
        return fit && !mis && (KLEN_W'(pos) == klen);
    endfunction

    // wanted key character at the current position
    always_comb
    begin
        want = 8'd0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            if (pos_reg == KPOS_W'(i))
            begin
                want = key_text[i*8 +: 8];
            end
        end
    end

    assign key_in_range = (KLEN_W'(pos_reg) < key_length) && (pos_reg < KPOS_W'(KEY_CHARS));
    assign key_fit      = (key_length != '0) && (key_length <= KLEN_W'(KEY_CHARS));

    always_comb
    begin
        logic [7:0] c;
        logic [4:0] hx;
        logic       plain;
        logic       emit;
        logic [7:0] dec;
        logic       have;

        c     = step.item.in_byte;
        hx    = hex_value(c);
        plain = 1'b1;
        emit  = 1'b0;
        dec   = 8'd0;
        have  = 1'b0;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        mis_next     = mis_reg;
        seen_next    = seen_reg;
        esc_val_next = esc_val_reg;
        esc_next     = esc_reg;
        cut_next     = cut_reg;
        bad_next     = bad_reg;

        case (phase_reg)
            PH_KEY:
            begin
                if (c == CH_AMP)
                begin
                    if (pos_reg != '0 && key_match(pos_reg, mis_reg, key_fit, key_length))
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_DONE;
                    end
                    pos_next = '0;
                    mis_next = 1'b0;
                end
                else if (c == CH_EQ)
                begin
                    if (key_match(pos_reg, mis_reg, key_fit, key_length))
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    if (!key_in_range || (to_lower(want) != to_lower(c)))
                    begin
                        mis_next = 1'b1;
                    end
                    if (pos_reg != '1)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            PH_VALUE:
            begin
                if (esc_reg != ESC_IDLE)
                begin
                    if (hx[4])
                    begin
                        plain = 1'b0;
                        if (esc_reg == ESC_FIRST)
                        begin
                            esc_val_next = hx[3:0];
                            esc_next     = ESC_SECOND;
                        end
                        else
                        begin
                            esc_next = ESC_IDLE;
                            emit     = 1'b1;
                            dec      = {esc_val_reg, hx[3:0]};
                        end
                    end
                    else
                    begin
                        bad_next = 1'b1;
                        esc_next = ESC_IDLE;
                    end
                end
                if (plain)
                begin
                    if (c == CH_AMP)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (c == CH_PCT)
                    begin
                        esc_next = ESC_FIRST;
                    end
                    else
                    begin
                        emit = 1'b1;
                        dec  = (c == CH_PLUS) ? CH_SPACE : c;
                    end
                end
                if (emit && !cut_reg)
                begin
                    if (dec == 8'd0)
                    begin
                        cut_next = 1'b1;
                    end
                    else
                    begin
                        have = 1'b1;
                    end
                end
            end
            PH_SKIP:
            begin
                if (c == CH_AMP)
                begin
                    phase_next = PH_KEY;
                    pos_next   = '0;
                    mis_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        res.have                 = have || step.item.in_last;
        res.item.out_byte        = have ? dec : 8'd0;
        res.item.byte_valid      = have;
        res.item.value_end       = step.item.in_last;
        res.item.found           = 1'b0;
        res.item.malformed       = 1'b0;

        if (step.item.in_last)
        begin
            if (phase_next == PH_KEY && pos_next != '0
                && key_match(pos_next, mis_next, key_fit, key_length))
            begin
                seen_next = 1'b1;
            end
            if (phase_next == PH_VALUE && esc_next != ESC_IDLE)
            begin
                bad_next = 1'b1;
            end
            res.item.found     = seen_next;
            res.item.malformed = bad_next;

            phase_next   = PH_KEY;
            pos_next     = '0;
            mis_next     = 1'b0;
            seen_next    = 1'b0;
            esc_val_next = 4'd0;
            esc_next     = ESC_IDLE;
            cut_next     = 1'b0;
            bad_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_KEY;
            pos_reg     <= '0;
            mis_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            esc_val_reg <= 4'd0;
            esc_reg     <= ESC_IDLE;
            cut_reg     <= 1'b0;
            bad_reg     <= 1'b0;
        end
        else if (step.fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            mis_reg     <= mis_next;
            seen_reg    <= seen_next;
            esc_val_reg <= esc_val_next;
            esc_reg     <= esc_next;
            cut_reg     <= cut_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import qpe_pkg::*;

    localparam int KEY_CHARS     = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 226;
    localparam int MAX_PRINTS    = 30;

    class value_scoreboard;
        localparam int KEY_MAX = 8;

        logic [63:0] key_text;
        logic [3:0]  key_len;
        phase_t      ph;
        logic [3:0]  key_pos;
        bit          key_off;
        bit          key_hit_seen;
        logic [3:0]  esc_hi;
        esc_t        esc;
        bit          cut;
        bit          bad_esc;
        out_item_t   pending[$];
        int          errors;
        int          n_chars;
        int          n_values;
        int          n_queries;
        int          n_found;
        int          n_bad;

        function new();
            key_text  = '0;
            key_len   = '0;
            errors    = 0;
            n_chars   = 0;
            n_values  = 0;
            n_queries = 0;
            n_found   = 0;
            n_bad     = 0;
            restart();
        endfunction

        function void restart();
            ph           = PH_KEY;
            key_pos      = '0;
            key_off      = 1'b0;
            key_hit_seen = 1'b0;
            esc_hi       = '0;
            esc          = ESC_IDLE;
            cut          = 1'b0;
            bad_esc      = 1'b0;
        endfunction

        function logic [7:0] fold(input logic [7:0] c);
            if (c >= "A" && c <= "Z")
            begin
                return c + 8'd32;
            end
            return c;
        endfunction

        function int hex_nibble(input logic [7:0] c);
            if (c >= "0" && c <= "9")
            begin
                return int'(c - "0");
            end
            if (c >= "A" && c <= "F")
            begin
                return int'(c - "A") + 10;
            end
            if (c >= "a" && c <= "f")
            begin
                return int'(c - "a") + 10;
            end
            return -1;
        endfunction

        function bit key_complete();
            return key_len >= 1 && key_len <= KEY_MAX && !key_off && key_pos == key_len;
        endfunction

        // advance the parser by one query character and queue what it yields
        function void note_query(input in_item_t it);
            logic [7:0] c;
            logic [7:0] dec;
            logic [7:0] want;
            bit         emit;
            bit         have;
            bit         consumed;
            int         h;
            out_item_t  r;
            c        = it.in_byte;
            dec      = '0;
            emit     = 1'b0;
            have     = 1'b0;
            consumed = 1'b0;
            r        = '0;
            n_chars++;
            case (ph)
                PH_KEY:
                begin
                    if (c == CH_AMP)
                    begin
                        if (key_pos != 0 && key_complete())
                        begin
                            key_hit_seen = 1'b1;
                            ph = PH_DONE;
                        end
                        key_pos = '0;
                        key_off = 1'b0;
                    end
                    else if (c == CH_EQ)
                    begin
                        if (key_complete())
                        begin
                            key_hit_seen = 1'b1;
                            ph = PH_VALUE;
                        end
                        else
                        begin
                            ph = PH_SKIP;
                        end
                    end
                    else
                    begin
                        if (key_pos < key_len && key_pos < KEY_MAX)
                        begin
                            want = key_text[8*key_pos +: 8];
                            if (fold(want) != fold(c))
                            begin
                                key_off = 1'b1;
                            end
                        end
                        else
                        begin
                            key_off = 1'b1;
                        end
                        if (key_pos != 4'd15)
                        begin
                            key_pos++;
                        end
                    end
                end
                PH_VALUE:
                begin
                    if (esc != ESC_IDLE)
                    begin
                        h = hex_nibble(c);
                        if (h >= 0)
                        begin
                            consumed = 1'b1;
                            if (esc == ESC_FIRST)
                            begin
                                esc_hi = h[3:0];
                                esc = ESC_SECOND;
                            end
                            else
                            begin
                                esc = ESC_IDLE;
                                dec = {esc_hi, h[3:0]};
                                emit = 1'b1;
                            end
                        end
                        else
                        begin
                            bad_esc = 1'b1;
                            esc = ESC_IDLE;
                        end
                    end
                    if (!consumed)
                    begin
                        if (c == CH_AMP)
                        begin
                            ph = PH_DONE;
                        end
                        else if (c == CH_PCT)
                        begin
                            esc = ESC_FIRST;
                        end
                        else
                        begin
                            dec = (c == CH_PLUS) ? CH_SPACE : c;
                            emit = 1'b1;
                        end
                    end
                    if (emit && !cut)
                    begin
                        if (dec == 8'h00)
                        begin
                            cut = 1'b1;
                        end
                        else
                        begin
                            have = 1'b1;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (c == CH_AMP)
                    begin
                        ph = PH_KEY;
                        key_pos = '0;
                        key_off = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            if (it.in_last)
            begin
                if (ph == PH_KEY && key_pos != 0 && key_complete())
                begin
                    key_hit_seen = 1'b1;
                end
                if (ph == PH_VALUE && esc != ESC_IDLE)
                begin
                    bad_esc = 1'b1;
                end
                r.out_byte   = have ? dec : 8'h00;
                r.byte_valid = have;
                r.value_end  = 1'b1;
                r.found      = key_hit_seen;
                r.malformed  = bad_esc;
                pending.push_back(r);
                n_queries++;
                n_found += key_hit_seen;
                n_bad += bad_esc;
                restart();
            end
            else if (have)
            begin
                r.out_byte   = dec;
                r.byte_valid = 1'b1;
                pending.push_back(r);
            end
        endfunction

        task report(input string what);
            errors++;
            if (errors <= MAX_PRINTS)
            begin
                $display("%0t mismatch: %s", $time, what);
            end
        endtask

        task check_value(input out_item_t got);
            out_item_t want;
            n_values++;
            if (pending.size() == 0)
            begin
                report($sformatf("value transaction %h with nothing outstanding", got));
                return;
            end
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                report($sformatf("out_byte %h, predicted %h", got.out_byte, want.out_byte));
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                report($sformatf("byte_valid %b, predicted %b", got.byte_valid,
                    want.byte_valid));
            end
            if (got.value_end !== want.value_end)
            begin
                report($sformatf("value_end %b, predicted %b", got.value_end,
                    want.value_end));
            end
            if (got.found !== want.found)
            begin
                report($sformatf("found %b, predicted %b", got.found, want.found));
            end
            if (got.malformed !== want.malformed)
            begin
                report($sformatf("malformed %b, predicted %b", got.malformed,
                    want.malformed));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    qpe_stream_if #(.item_t(in_item_t))  query_if ();
    qpe_stream_if #(.item_t(out_item_t)) value_if ();

    query_param_extract_url_decode #(
        .KEY_CHARS (KEY_CHARS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_if),
        .value     (value_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    value_scoreboard sb;
    logic [7:0]      qchars[$];
    logic [7:0]      key_chars[8];
    logic [3:0]      key_len_cfg;
    int              items_sent;
    int              burst_left;
    bit              calm;
    int              idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall pattern
    initial
    begin
        int  mode;
        int  mode_left;
        int  run_left;
        int  tick;
        bit  level;
        value_if.ready = 1'b0;
        mode_left = 0;
        run_left = 0;
        tick = 0;
        level = 1'b1;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            tick++;
            case (mode)
                0: value_if.ready <= 1'b1;
                1: value_if.ready <= 1'($urandom_range(0, 1));
                2: value_if.ready <= (tick % 7) >= 3;
                default:
                begin
                    if (run_left == 0)
                    begin
                        level = !level;
                        run_left = level ? $urandom_range(1, 6) : $urandom_range(1, 10);
                    end
                    run_left--;
                    value_if.ready <= level;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && query_if.valid && query_if.ready)
        begin
            sb.note_query(query_if.payload);
        end
        if (rst_n && value_if.valid && value_if.ready)
        begin
            sb.check_value(value_if.payload);
        end
        if ((query_if.valid && query_if.ready) || (value_if.valid && value_if.ready) ||
            cfg_write)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin
        idle_cycles = 0;
        do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
        $display("no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1))
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 10)
        begin
            r = "0" + n;
        end
        else if ($urandom_range(0, 1))
        begin
            r = "A" + n - 8'd10;
        end
        else
        begin
            r = "a" + n - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CH_AMP;
            1: c = CH_PLUS;
            2: c = CH_PCT;
            default:
            begin
                do c = 8'($urandom_range(0, 255)); while (sb.hex_nibble(c) >= 0);
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] key_pool_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2: c = "a" + 8'($urandom_range(0, 25));
            3, 4:    c = "A" + 8'($urandom_range(0, 25));
            5:       c = "0" + 8'($urandom_range(0, 9));
            default:
            begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_AMP || c == CH_EQ);
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = "a" + 8'($urandom_range(0, 25));
            1: c = "A" + 8'($urandom_range(0, 25));
            2: c = "0" + 8'($urandom_range(0, 9));
            3: c = CH_PLUS;
            4: c = CH_EQ;
            default:
            begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_AMP || c == CH_PCT);
            end
        endcase
        return c;
    endfunction

    function automatic void add_key();
        int n;
        int i;
        int pos;
        n = (key_len_cfg > KEY_CHARS) ? KEY_CHARS : key_len_cfg;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                for (i = 0; i < n; i++) qchars.push_back(flip_case(key_chars[i]));
                if (key_len_cfg > KEY_CHARS)
                begin
                    qchars.push_back(key_pool_char());
                end
            end
            5:
            begin
                for (i = 0; i < n - 1; i++) qchars.push_back(flip_case(key_chars[i]));
            end
            6:
            begin
                for (i = 0; i < n; i++) qchars.push_back(flip_case(key_chars[i]));
                qchars.push_back(key_pool_char());
            end
            7:
            begin
                pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
                for (i = 0; i < n; i++)
                begin
                    qchars.push_back((i == pos) ? key_pool_char() : key_chars[i]);
                end
            end
            8:
            begin
            end
            default:
            begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++) qchars.push_back(key_pool_char());
            end
        endcase
    endfunction

    function automatic void add_value();
        int         n;
        int         i;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: qchars.push_back(plain_char());
                5, 6:
                begin
                    qchars.push_back(CH_PCT);
                    qchars.push_back(hex_char(b[7:4]));
                    qchars.push_back(hex_char(b[3:0]));
                end
                7: qchars.push_back(8'h00);
                8:
                begin
                    qchars.push_back(CH_PCT);
                    qchars.push_back(non_hex_char());
                end
                9:
                begin
                    qchars.push_back(CH_PCT);
                    qchars.push_back(hex_char(b[3:0]));
                    qchars.push_back(non_hex_char());
                end
                10:
                begin
                    qchars.push_back(CH_PCT);
                    qchars.push_back(hex_char(4'h0));
                    qchars.push_back(hex_char(4'h0));
                end
                default:
                begin
                    // escape cut off at the end of the value
                    if (i == n - 1)
                    begin
                        qchars.push_back(CH_PCT);
                        if ($urandom_range(0, 1))
                        begin
                            qchars.push_back(hex_char(b[3:0]));
                        end
                    end
                    else
                    begin
                        qchars.push_back(plain_char());
                    end
                end
            endcase
        end
    endfunction

    function automatic void build_query();
        int n;
        int i;
        qchars.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 7))
                    0: qchars.push_back(CH_AMP);
                    1: qchars.push_back(CH_EQ);
                    2: qchars.push_back(CH_PCT);
                    3: qchars.push_back(CH_PLUS);
                    default: qchars.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                if (i > 0)
                begin
                    qchars.push_back(CH_AMP);
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    qchars.push_back(CH_AMP);
                end
                add_key();
                if ($urandom_range(0, 6) != 0)
                begin
                    qchars.push_back(CH_EQ);
                    add_value();
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                qchars.push_back(CH_AMP);
            end
            if (qchars.size() > 0 && $urandom_range(0, 9) == 0)
            begin
                qchars[$urandom_range(0, qchars.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        if (qchars.size() == 0)
        begin
            qchars.push_back(key_pool_char());
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = calm ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                query_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        query_if.valid <= 1'b1;
        query_if.payload <= '{in_byte: c, in_last: l};
        do @(posedge clk); while (!query_if.ready);
        items_sent++;
    endtask

    task automatic send_query();
        int i;
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < qchars.size(); i++)
        begin
            send_char(qchars[i], i == qchars.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        qchars.delete();
        for (i = 0; i < s.len(); i++) qchars.push_back(s.getc(i));
        send_query();
    endtask

    // hold the query side until every predicted transaction has come out
    task automatic drain();
        query_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_key(input logic [63:0] txt, input logic [3:0] len);
        int i;
        cfg_write <= 1'b1;
        cfg_index <= REG_KEY_TEXT;
        cfg_data <= txt;
        @(posedge clk);
        cfg_index <= REG_KEY_LENGTH;
        cfg_data <= {{(CFG_DATA_W-KLEN_W){1'b0}}, len};
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.key_text = txt;
        sb.key_len = len;
        for (i = 0; i < 8; i++) key_chars[i] = txt[8*i +: 8];
        key_len_cfg = len;
    endtask

    initial
    begin
        int          p;
        int          i;
        int          phase_end;
        logic [63:0] txt;
        logic [3:0]  len;
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_KEY_TEXT;
        cfg_data = '0;
        query_if.valid = 1'b0;
        query_if.payload = '0;
        items_sent = 0;
        burst_left = 0;
        calm = 1'b0;
        key_len_cfg = '0;
        for (i = 0; i < 8; i++) key_chars[i] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pairs, case-blind match, escapes, bare key, empty key,
        // decoded zero and an escape cut off by the end of the query
        set_key({48'h0, "b", "A"}, 4'd2);
        send_text("&&aB=%4a+%G");
        send_text("ab");
        send_text("=x&ab=%00y%4");
        drain();

        for (p = 0; p < 8; p++)
        begin
            for (i = 0; i < 8; i++) txt[8*i +: 8] = key_pool_char();
            case (p)
                0: len = 4'd0;
                1: len = 4'd1;
                2: len = 4'd8;
                3:
                begin
                    txt = '1;
                    len = 4'd8;
                end
                4: len = 4'd9;
                5: len = 4'($urandom_range(2, 7));
                6:
                begin
                    txt[15:8] = 8'h00;
                    txt[31:24] = 8'h00;
                    len = 4'd4;
                end
                default:
                begin
                    txt = {$urandom, $urandom};
                    len = 4'd3;
                end
            endcase
            set_key(txt, len);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                build_query();
                send_query();
                if ($urandom_range(0, 19) == 0)
                begin
                    drain();
                end
            end
            drain();
        end

        $display("%0d queries, %0d characters, %0d value transactions checked over 9 keys",
            sb.n_queries, sb.n_chars, sb.n_values);
        $display("key found in %0d queries, bad or cut-off escape in %0d, %0d mismatches",
            sb.n_found, sb.n_bad, sb.errors);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
